[src/mvts_pkg.sv]
`timescale 1ns / 1ps
package mvts_pkg;

    localparam int FUNC_W  = 4;
    localparam int ID_W    = 5;
    localparam int LVL_W   = 3;
    localparam int PRIO_W  = 8;
    localparam int NS_W    = 32;
    localparam int SEL_W   = 3;
    localparam int STS_W   = 2;
    localparam int DROP_W  = 5;
    localparam int VAL_W   = 32;
    localparam int VR_W    = 64;
    localparam int ORD_W   = 32;
    localparam int WGT_W   = 9;
    localparam int NSTAT   = 6;

    localparam logic [NS_W-1:0] TICK_LEN_RESET = 32'd1000000;

    localparam int C_TOTAL     = 0;
    localparam int C_ACTIVE    = 1;
    localparam int C_COMPLETED = 2;
    localparam int C_FAILED    = 3;
    localparam int C_SWITCHES  = 4;
    localparam int C_PREEMPT   = 5;

    typedef enum logic [FUNC_W-1:0] {
        F_CREATE  = 4'd0,
        F_DESTROY = 4'd1,
        F_SUBMIT  = 4'd2,
        F_SUSPEND = 4'd3,
        F_RESUME  = 4'd4,
        F_SETPRIO = 4'd5,
        F_GETPRIO = 4'd6,
        F_PICK    = 4'd7,
        F_TICK    = 4'd8,
        F_YIELD   = 4'd9,
        F_PREEMPT = 4'd10,
        F_STAT    = 4'd11
    } t_func;

    typedef enum logic [STS_W-1:0] {
        RS_OK      = 2'd0,
        RS_INVALID = 2'd1,
        RS_FULL    = 2'd2
    } t_rstat;

    typedef enum logic [2:0] {
        TS_READY     = 3'd0,
        TS_RUNNING   = 3'd1,
        TS_SUSPENDED = 3'd2,
        TS_COMPLETED = 3'd3,
        TS_FAILED    = 3'd4
    } t_tstat;

    typedef struct packed {
        logic [LVL_W-1:0]  level;
        logic [PRIO_W-1:0] prio;
        logic [NS_W-1:0]   slice;
        logic [NS_W-1:0]   dl;
        logic [VR_W-1:0]   vr;
        logic [VR_W-1:0]   ex;
        t_tstat            st;
        logic [ORD_W-1:0]  ord;
        logic [VR_W-1:0]   ls;
    } t_rec;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_DECODE,
        OP_RD,
        OP_CAP,
        OP_EXEC,
        OP_SCAN_START,
        OP_SCAN,
        OP_PSEL,
        OP_DIV_START,
        OP_DIV,
        OP_MUL,
        OP_TCHK,
        OP_APPLY,
        OP_FIN
    } t_op;

    typedef struct packed {
        t_op op;
    } t_cmd;

    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic              direct;
        logic              tgt_ok;
        logic              bad;
        logic              scan_done;
        logic              div_done;
        logic              pick_none;
        logic              again;
        logic              expired;
        logic              out_free;
    } t_flags;

    function automatic logic [PRIO_W-1:0] weight_base(input logic [LVL_W-1:0] lvl);
        logic [PRIO_W-1:0] b;
        case (lvl)
            3'd0: b = 8'd1;
            3'd1: b = 8'd4;
            3'd2: b = 8'd16;
            3'd3: b = 8'd32;
            3'd4: b = 8'd64;
            default: b = 8'd128;
        endcase
        return b;
    endfunction

endpackage

[src/mvts_ram.sv]
`timescale 1ns / 1ps
module mvts_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

[src/mvts_ctrl.sv]
`timescale 1ns / 1ps
module mvts_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_stall,
    input  mvts_pkg::t_flags i_flags,
    output mvts_pkg::t_cmd  o_cmd
);
    import mvts_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_DECODE, S_RD, S_CAP, S_EXEC, S_SCAN_START, S_SCAN, S_PSEL,
        S_DIV_START, S_DIV, S_MUL, S_TCHK, S_APPLY, S_FIN
    } t_state;

    t_state r_state, n_state;

    always_comb begin
        n_state = r_state;
        o_cmd.op = OP_NONE;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.op = OP_LOAD;
                    n_state  = S_DECODE;
                end
            end
            S_DECODE: begin
                o_cmd.op = OP_DECODE;
                if (i_flags.direct) begin
                    n_state = S_APPLY;
                end else if (i_flags.func == F_PICK) begin
                    n_state = S_SCAN_START;
                end else if (!i_flags.tgt_ok) begin
                    n_state = S_FIN;
                end else begin
                    n_state = S_RD;
                end
            end
            S_RD: begin
                o_cmd.op = OP_RD;
                n_state  = S_CAP;
            end
            S_CAP: begin
                o_cmd.op = OP_CAP;
                n_state  = S_EXEC;
            end
            S_EXEC: begin
                o_cmd.op = OP_EXEC;
                if (i_flags.bad) begin
                    n_state = S_FIN;
                end else if (i_flags.func == F_TICK) begin
                    n_state = S_DIV_START;
                end else if (i_flags.func == F_SUBMIT) begin
                    n_state = S_SCAN_START;
                end else begin
                    n_state = S_APPLY;
                end
            end
            S_SCAN_START: begin
                o_cmd.op = OP_SCAN_START;
                n_state  = S_SCAN;
            end
            S_SCAN: begin
                o_cmd.op = OP_SCAN;
                if (i_flags.scan_done) begin
                    n_state = (i_flags.func == F_PICK) ? S_PSEL : S_APPLY;
                end
            end
            S_PSEL: begin
                o_cmd.op = OP_PSEL;
                n_state  = i_flags.pick_none ? S_FIN : S_RD;
            end
            S_DIV_START: begin
                o_cmd.op = OP_DIV_START;
                n_state  = S_DIV;
            end
            S_DIV: begin
                o_cmd.op = OP_DIV;
                if (i_flags.div_done) begin
                    n_state = S_MUL;
                end
            end
            S_MUL: begin
                o_cmd.op = OP_MUL;
                n_state  = S_TCHK;
            end
            S_TCHK: begin
                o_cmd.op = OP_TCHK;
                n_state  = i_flags.expired ? S_APPLY : S_SCAN_START;
            end
            S_APPLY: begin
                o_cmd.op = OP_APPLY;
                n_state  = i_flags.again ? S_SCAN_START : S_FIN;
            end
            S_FIN: begin
                o_cmd.op = OP_FIN;
                if (i_flags.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_stall = (r_state != S_IDLE);
endmodule

[src/mvts_dp.sv]
`timescale 1ns / 1ps
module mvts_dp #(
    parameter int TASK_SLOTS = 16,
    parameter int LEVELS     = 6
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  mvts_pkg::t_cmd                i_cmd,
    output mvts_pkg::t_flags              o_flags,
    input  logic [mvts_pkg::FUNC_W-1:0]   i_func,
    input  logic [mvts_pkg::ID_W-1:0]     i_task_id,
    input  logic [mvts_pkg::LVL_W-1:0]    i_policy_level,
    input  logic [mvts_pkg::PRIO_W-1:0]   i_new_priority,
    input  logic [mvts_pkg::NS_W-1:0]     i_slice_ns,
    input  logic [mvts_pkg::NS_W-1:0]     i_deadline_limit_ns,
    input  logic [mvts_pkg::SEL_W-1:0]    i_stat_select,
    input  logic                          i_cfg_we,
    input  logic [mvts_pkg::NS_W-1:0]     i_cfg_wdata,
    input  logic                          i_stall,
    output logic                          o_valid,
    output logic [mvts_pkg::STS_W-1:0]    o_status,
    output logic [mvts_pkg::ID_W-1:0]     o_result_task_id,
    output logic [mvts_pkg::VAL_W-1:0]    o_result_value,
    output logic [mvts_pkg::DROP_W-1:0]   o_dropped_count
);
    import mvts_pkg::*;

    localparam int SW = $clog2(TASK_SLOTS);
    localparam int CW = $clog2(TASK_SLOTS + 1);
    localparam int XW = (CW > ID_W) ? CW : ID_W;
    localparam int LW = $clog2(LEVELS);

    // latched command
    logic [FUNC_W-1:0] r_func;
    logic [ID_W-1:0]   r_id;
    logic [LVL_W-1:0]  r_plvl;
    logic [PRIO_W-1:0] r_prio;
    logic [NS_W-1:0]   r_slice;
    logic [NS_W-1:0]   r_dl;
    logic [SEL_W-1:0]  r_sel;

    // scheduler state
    logic [NS_W-1:0]   r_tl;
    logic [CW-1:0]     r_alloc;
    logic [CW-1:0]     r_running;
    logic [VR_W-1:0]   r_tick;
    logic [ORD_W-1:0]  r_order;
    logic [VAL_W-1:0]  r_stat [NSTAT];
    logic              r_queued [TASK_SLOTS];

    logic [SW-1:0]     r_tgt;
    t_rec              r_rec;
    logic [LW-1:0]     r_tlvl;

    // scan
    logic [CW-1:0]     r_sidx;
    logic              r_pv;
    logic [SW-1:0]     r_pslot;
    logic              r_hb_vld  [LEVELS];
    logic [SW-1:0]     r_hb_slot [LEVELS];
    logic [VR_W-1:0]   r_hb_vr   [LEVELS];
    logic [ORD_W-1:0]  r_hb_ord  [LEVELS];

    // divider and expiry check
    logic [NS_W-1:0]   r_dq;
    logic [WGT_W-1:0]  r_rem;
    logic [WGT_W-1:0]  r_dvs;
    logic [4:0]        r_dcnt;
    logic [VR_W-1:0]   r_prod;
    logic              r_ehi;
    logic              r_expired;

    // result being built and output register
    logic [STS_W-1:0]  r_rs;
    logic [ID_W-1:0]   r_rid;
    logic [VAL_W-1:0]  r_rval;
    logic [DROP_W-1:0] r_rdrop;
    logic              r_ovld;
    logic [STS_W-1:0]  r_o_status;
    logic [ID_W-1:0]   r_o_rid;
    logic [VAL_W-1:0]  r_o_rval;
    logic [DROP_W-1:0] r_o_drop;

    t_rec              ram_rdata;
    logic              ram_we;
    logic [SW-1:0]     ram_waddr;
    logic [SW-1:0]     ram_raddr;
    t_rec              a_rec;
    logic              a_we;
    logic              a_enq;
    logic              a_qclr;
    logic              a_runclr;

    logic [XW-1:0]     id_x;
    logic [XW-1:0]     id_m1;
    logic [CW-1:0]     run_m1;
    logic              id_ok;
    logic              run_ok;
    logic              needs_id;
    logic              direct;
    logic              tgt_ok;
    logic              bad;
    logic [LW-1:0]     rec_ql;
    logic [LW-1:0]     scan_ql;
    logic              hs_vld;
    logic [VR_W-1:0]   hs_vr;
    logic              psel_any;
    logic [LW-1:0]     psel_lvl;
    logic [SW-1:0]     psel_slot;
    logic              higher_wait;
    logic              pick_fail;
    logic [CW-1:0]     tgt_id;
    logic              scan_issue;
    logic [WGT_W:0]    div_t;
    logic              div_ge;
    logic [WGT_W-1:0]  div_nrem;
    logic [VR_W-1:0]   elapsed;
    logic              expired_c;
    logic              out_free;
    logic              fin_load;

    assign id_x   = XW'(r_id);
    assign id_m1  = id_x - XW'(1);
    assign run_m1 = r_running - CW'(1);
    assign id_ok  = (r_id != '0) && (id_x <= XW'(r_alloc));
    assign run_ok = (r_running != '0) && (r_running <= r_alloc);
    assign tgt_id = CW'(r_tgt) + CW'(1);

    always_comb begin
        needs_id = 1'b0;
        direct   = 1'b0;
        tgt_ok   = id_ok;
        case (r_func)
            F_CREATE, F_STAT: direct = 1'b1;
            F_DESTROY, F_SUBMIT, F_SUSPEND, F_RESUME, F_SETPRIO, F_GETPRIO,
            F_PREEMPT: needs_id = 1'b1;
            F_TICK, F_YIELD: tgt_ok = run_ok;
            F_PICK: tgt_ok = 1'b1;
            default: direct = 1'b1;
        endcase
    end

    assign rec_ql  = (r_rec.level >= LVL_W'(LEVELS - 1)) ? LW'(LEVELS - 1)
                                                         : r_rec.level[LW-1:0];
    assign scan_ql = (ram_rdata.level >= LVL_W'(LEVELS - 1)) ? LW'(LEVELS - 1)
                                                             : ram_rdata.level[LW-1:0];

    always_comb begin
        bad = 1'b0;
        case (r_func)
            F_SUBMIT:  bad = r_queued[r_tgt] ||
                             !((r_rec.st == TS_READY) || (r_rec.st == TS_SUSPENDED));
            F_RESUME:  bad = (r_rec.st != TS_SUSPENDED);
            F_PREEMPT: bad = (r_rec.st != TS_RUNNING);
            default:   bad = 1'b0;
        endcase
    end

    assign hs_vld = r_hb_vld[r_tlvl];
    assign hs_vr  = r_hb_vr[r_tlvl];

    // lowest nonempty level wins
    always_comb begin
        psel_any  = 1'b0;
        psel_lvl  = '0;
        psel_slot = '0;
        for (int i = LEVELS - 1; i >= 0; i--) begin
            if (r_hb_vld[i]) begin
                psel_any  = 1'b1;
                psel_lvl  = LW'(i);
                psel_slot = r_hb_slot[i];
            end
        end
    end

    always_comb begin
        higher_wait = 1'b0;
        for (int i = 0; i < LEVELS; i++) begin
            if (r_hb_vld[i] && (LW'(i) < rec_ql)) begin
                higher_wait = 1'b1;
            end
        end
    end

    assign pick_fail = (r_tlvl == '0) && (r_rec.dl != '0) &&
                       (r_rec.ex > VR_W'(r_rec.dl));

    assign scan_issue = (r_sidx < r_alloc);

    assign div_t    = {r_rem, r_dq[NS_W-1]};
    assign div_ge   = (div_t >= {1'b0, r_dvs});
    assign div_nrem = div_ge ? WGT_W'(div_t - {1'b0, r_dvs}) : div_t[WGT_W-1:0];

    assign elapsed   = r_tick - r_rec.ls;
    assign expired_c = (r_ehi && (r_tl != '0)) || (r_prod >= VR_W'(r_rec.slice));

    assign out_free = !r_ovld || !i_stall;
    assign fin_load = (i_cmd.op == OP_FIN) && out_free;

    // record update for the apply step
    always_comb begin
        a_rec    = r_rec;
        a_we     = 1'b1;
        a_enq    = 1'b0;
        a_qclr   = 1'b0;
        a_runclr = 1'b0;
        ram_waddr = r_tgt;
        case (r_func)
            F_CREATE: begin
                ram_waddr   = r_alloc[SW-1:0];
                a_we        = (r_alloc < CW'(TASK_SLOTS));
                a_rec.level = r_plvl;
                a_rec.prio  = r_prio;
                a_rec.slice = r_slice;
                a_rec.dl    = r_dl;
                a_rec.vr    = '0;
                a_rec.ex    = '0;
                a_rec.st    = TS_READY;
                a_rec.ord   = '0;
                a_rec.ls    = '0;
            end
            F_DESTROY, F_SUSPEND: begin
                a_runclr = (r_rec.st == TS_RUNNING);
                a_qclr   = 1'b1;
                a_rec.st = (r_func == F_DESTROY) ? TS_COMPLETED : TS_SUSPENDED;
            end
            F_SUBMIT: begin
                if (hs_vld) begin
                    a_rec.vr = hs_vr;
                end
                a_enq = 1'b1;
            end
            F_RESUME: a_enq = 1'b1;
            F_SETPRIO: begin
                a_rec.prio = r_prio;
                a_enq      = r_queued[r_tgt];
            end
            F_GETPRIO: a_we = 1'b0;
            F_PICK: begin
                a_qclr = 1'b1;
                if (pick_fail) begin
                    a_rec.st = TS_FAILED;
                end else begin
                    a_rec.st = TS_RUNNING;
                    a_rec.ls = r_tick;
                end
            end
            F_TICK: begin
                a_runclr = r_expired || higher_wait;
                a_enq    = r_expired || higher_wait;
            end
            F_YIELD, F_PREEMPT: begin
                a_runclr = 1'b1;
                a_enq    = 1'b1;
            end
            default: a_we = 1'b0;
        endcase
        if (a_enq) begin
            a_rec.ord = r_order;
            a_rec.st  = TS_READY;
        end
    end

    assign ram_we    = (i_cmd.op == OP_APPLY) && a_we;
    assign ram_raddr = (i_cmd.op == OP_SCAN) ? r_sidx[SW-1:0] : r_tgt;

    mvts_ram #(
        .WIDTH ($bits(t_rec)),
        .DEPTH (TASK_SLOTS)
    ) u_tab (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (a_rec),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tl      <= TICK_LEN_RESET;
            r_alloc   <= '0;
            r_running <= '0;
            r_tick    <= '0;
            r_order   <= '0;
            r_ovld    <= 1'b0;
            r_pv      <= 1'b0;
            for (int i = 0; i < NSTAT; i++) begin
                r_stat[i] <= '0;
            end
            for (int i = 0; i < TASK_SLOTS; i++) begin
                r_queued[i] <= 1'b0;
            end
        end else begin
            if (i_cfg_we) begin
                r_tl <= i_cfg_wdata;
            end
            if (fin_load) begin
                r_ovld <= 1'b1;
            end else if (!i_stall) begin
                r_ovld <= 1'b0;
            end
            if (i_cmd.op == OP_SCAN) begin
                r_pv <= scan_issue;
            end else begin
                r_pv <= 1'b0;
            end
            if ((i_cmd.op == OP_DECODE) && (r_func == F_TICK)) begin
                r_tick <= r_tick + VR_W'(1);
            end
            if (i_cmd.op == OP_APPLY) begin
                if (a_enq) begin
                    r_queued[r_tgt] <= 1'b1;
                    r_order         <= r_order + ORD_W'(1);
                end
                if (a_qclr) begin
                    r_queued[r_tgt] <= 1'b0;
                end
                if (a_runclr) begin
                    r_running <= '0;
                end
                case (r_func)
                    F_CREATE: begin
                        if (a_we) begin
                            r_alloc                     <= r_alloc + CW'(1);
                            r_queued[r_alloc[SW-1:0]]   <= 1'b0;
                            r_stat[C_TOTAL]             <= r_stat[C_TOTAL] + VAL_W'(1);
                            r_stat[C_ACTIVE]            <= r_stat[C_ACTIVE] + VAL_W'(1);
                        end
                    end
                    F_DESTROY: begin
                        r_stat[C_ACTIVE]    <= r_stat[C_ACTIVE] - VAL_W'(1);
                        r_stat[C_COMPLETED] <= r_stat[C_COMPLETED] + VAL_W'(1);
                    end
                    F_PICK: begin
                        if (pick_fail) begin
                            r_stat[C_FAILED] <= r_stat[C_FAILED] + VAL_W'(1);
                            r_stat[C_ACTIVE] <= r_stat[C_ACTIVE] - VAL_W'(1);
                        end else begin
                            if (r_running != tgt_id) begin
                                r_stat[C_SWITCHES] <= r_stat[C_SWITCHES] + VAL_W'(1);
                            end
                            r_running <= tgt_id;
                        end
                    end
                    F_TICK: begin
                        if (!r_expired && higher_wait) begin
                            r_stat[C_PREEMPT] <= r_stat[C_PREEMPT] + VAL_W'(1);
                        end
                    end
                    F_PREEMPT: begin
                        r_stat[C_PREEMPT] <= r_stat[C_PREEMPT] + VAL_W'(1);
                    end
                    default: ;
                endcase
            end
        end
    end

    // payload and working registers
    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            OP_LOAD: begin
                r_func  <= i_func;
                r_id    <= i_task_id;
                r_plvl  <= i_policy_level;
                r_prio  <= i_new_priority;
                r_slice <= i_slice_ns;
                r_dl    <= i_deadline_limit_ns;
                r_sel   <= i_stat_select;
                r_rs    <= RS_OK;
                r_rid   <= '0;
                r_rval  <= '0;
                r_rdrop <= '0;
            end
            OP_DECODE: begin
                if ((r_func == F_TICK) || (r_func == F_YIELD)) begin
                    r_tgt <= run_m1[SW-1:0];
                end else begin
                    r_tgt <= id_m1[SW-1:0];
                end
                if (needs_id && !id_ok) begin
                    r_rs <= RS_INVALID;
                end
            end
            OP_CAP: r_rec <= ram_rdata;
            OP_EXEC: begin
                r_tlvl <= rec_ql;
                if (bad) begin
                    r_rs <= RS_INVALID;
                end
            end
            OP_SCAN_START: begin
                r_sidx <= '0;
                for (int i = 0; i < LEVELS; i++) begin
                    r_hb_vld[i] <= 1'b0;
                end
            end
            OP_SCAN: begin
                r_pslot <= r_sidx[SW-1:0];
                if (scan_issue) begin
                    r_sidx <= r_sidx + CW'(1);
                end
            end
            OP_PSEL: begin
                r_tlvl <= psel_lvl;
                r_tgt  <= psel_slot;
            end
            OP_DIV_START: begin
                r_dq   <= r_rec.slice;
                r_rem  <= '0;
                r_dvs  <= WGT_W'(weight_base(r_rec.level)) + WGT_W'(r_rec.prio);
                r_dcnt <= '0;
            end
            OP_DIV: begin
                r_rem  <= div_nrem;
                r_dq   <= {r_dq[NS_W-2:0], div_ge};
                r_dcnt <= r_dcnt + 5'd1;
            end
            OP_MUL: begin
                r_prod <= VR_W'(elapsed[NS_W-1:0]) * VR_W'(r_tl);
                r_ehi  <= (elapsed[VR_W-1:NS_W] != '0);
            end
            OP_TCHK: begin
                r_expired <= expired_c;
                r_rec.vr  <= r_rec.vr + VR_W'(r_dq);
                r_rec.ex  <= r_rec.ex + VR_W'(r_rec.slice);
            end
            OP_APPLY: begin
                case (r_func)
                    F_CREATE: begin
                        if (a_we) begin
                            r_rid <= ID_W'(r_alloc + CW'(1));
                        end else begin
                            r_rs <= RS_FULL;
                        end
                    end
                    F_GETPRIO: r_rval <= VAL_W'(r_rec.prio);
                    F_STAT: begin
                        if (r_sel < SEL_W'(NSTAT)) begin
                            r_rval <= r_stat[r_sel];
                        end else begin
                            r_rs <= RS_INVALID;
                        end
                    end
                    F_PICK: begin
                        if (pick_fail) begin
                            r_rdrop <= r_rdrop + DROP_W'(1);
                        end else begin
                            r_rid <= ID_W'(tgt_id);
                        end
                    end
                    F_DESTROY, F_SUBMIT, F_SUSPEND, F_RESUME, F_SETPRIO, F_TICK,
                    F_YIELD, F_PREEMPT: ;
                    default: r_rs <= RS_INVALID;
                endcase
            end
            default: ;
        endcase

        // head of each level, lowest vruntime then oldest enqueue
        if (r_pv && r_queued[r_pslot]) begin
            for (int i = 0; i < LEVELS; i++) begin
                if ((scan_ql == LW'(i)) &&
                    (!r_hb_vld[i] || (ram_rdata.vr < r_hb_vr[i]) ||
                     ((ram_rdata.vr == r_hb_vr[i]) && (ram_rdata.ord < r_hb_ord[i])))) begin
                    r_hb_vld[i]  <= 1'b1;
                    r_hb_slot[i] <= r_pslot;
                    r_hb_vr[i]   <= ram_rdata.vr;
                    r_hb_ord[i]  <= ram_rdata.ord;
                end
            end
        end

        if (fin_load) begin
            r_o_status <= r_rs;
            r_o_rid    <= r_rid;
            r_o_rval   <= r_rval;
            r_o_drop   <= r_rdrop;
        end
    end

    always_comb begin
        o_flags.func      = r_func;
        o_flags.direct    = direct;
        o_flags.tgt_ok    = tgt_ok;
        o_flags.bad       = bad;
        o_flags.scan_done = !scan_issue;
        o_flags.div_done  = (r_dcnt == 5'd31);
        o_flags.pick_none = !psel_any;
        o_flags.again     = (r_func == F_PICK) && pick_fail;
        o_flags.expired   = expired_c;
        o_flags.out_free  = out_free;
    end

    assign o_valid          = r_ovld;
    assign o_status         = r_o_status;
    assign o_result_task_id = r_o_rid;
    assign o_result_value   = r_o_rval;
    assign o_dropped_count  = r_o_drop;

`ifndef SYNTH
    a_alloc_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_alloc <= CW'(TASK_SLOTS))
        else $error("task count beyond table size");

    a_running_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_running <= r_alloc)
        else $error("running task never created");

    a_running_not_queued: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_running != '0) |-> !r_queued[run_m1[SW-1:0]])
        else $error("running task still sits in a run queue");

    a_out_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fin_load |=> (o_status == RS_OK) || (o_status == RS_INVALID) ||
                     (o_status == RS_FULL))
        else $error("bad status on result beat");
`endif
endmodule

[src/multilevel_vruntime_task_scheduler_core.sv]
`timescale 1ns / 1ps
// one command at a time; o_stall stays high from the accepting edge until the result is
// loaded: create, stat and unknown codes apply directly, a bad task id or idle tick/yield
// goes straight to the result, other table commands read the record first, submit scans,
// pick scans then reads and rescans on each deadline drop, tick runs the 32-step divider
// and scans unless the slice expired; next beat taken once the result is registered
// reset (i_rst_n low, synchronous) empties the table and zeroes counters; no clearing pass
module multilevel_vruntime_task_scheduler_core #(
    parameter int TASK_SLOTS = 16,
    parameter int LEVELS     = 6
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_stall,
    input  logic [mvts_pkg::FUNC_W-1:0]  i_func,
    input  logic [mvts_pkg::ID_W-1:0]    i_task_id,
    input  logic [mvts_pkg::LVL_W-1:0]   i_policy_level,
    input  logic [mvts_pkg::PRIO_W-1:0]  i_new_priority,
    input  logic [mvts_pkg::NS_W-1:0]    i_slice_ns,
    input  logic [mvts_pkg::NS_W-1:0]    i_deadline_limit_ns,
    input  logic [mvts_pkg::SEL_W-1:0]   i_stat_select,
    input  logic                         i_cfg_we,
    input  logic [mvts_pkg::NS_W-1:0]    i_cfg_wdata,
    output logic                         o_valid,
    input  logic                         i_stall,
    output logic [mvts_pkg::STS_W-1:0]   o_status,
    output logic [mvts_pkg::ID_W-1:0]    o_result_task_id,
    output logic [mvts_pkg::VAL_W-1:0]   o_result_value,
    output logic [mvts_pkg::DROP_W-1:0]  o_dropped_count
);
    import mvts_pkg::*;

    t_cmd   cmd;
    t_flags flags;

    mvts_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_flags (flags),
        .o_cmd   (cmd)
    );

    mvts_dp #(
        .TASK_SLOTS (TASK_SLOTS),
        .LEVELS     (LEVELS)
    ) u_dp (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cmd               (cmd),
        .o_flags             (flags),
        .i_func              (i_func),
        .i_task_id           (i_task_id),
        .i_policy_level      (i_policy_level),
        .i_new_priority      (i_new_priority),
        .i_slice_ns          (i_slice_ns),
        .i_deadline_limit_ns (i_deadline_limit_ns),
        .i_stat_select       (i_stat_select),
        .i_cfg_we            (i_cfg_we),
        .i_cfg_wdata         (i_cfg_wdata),
        .i_stall             (i_stall),
        .o_valid             (o_valid),
        .o_status            (o_status),
        .o_result_task_id    (o_result_task_id),
        .o_result_value      (o_result_value),
        .o_dropped_count     (o_dropped_count)
    );
endmodule
